/* rtl/lpu8_pkg.sv */
// Shared types and constants of the length-prefixed UTF-8 decoder.
package lpu8_pkg;

  // Header phase codes.
  localparam logic [1:0] PH_LEN_LO = 2'd0;
  localparam logic [1:0] PH_LEN_HI = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  // Field widths.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CODE_W = 21;
  localparam int unsigned LEN_W  = 16;

  // UTF-8 lead thresholds and masks.
  localparam logic [7:0] LEAD2_MIN  = 8'h80;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD2_MASK = 8'h1F;
  localparam logic [7:0] LEAD3_MASK = 8'h0F;
  localparam logic [7:0] LEAD4_MASK = 8'h07;
  localparam logic [7:0] CONT_MASK  = 8'h3F;

  // UTF-16 surrogate constants.
  localparam logic [CODE_W-1:0] SUPP_BASE  = 21'h10000;
  localparam logic [CODE_W-1:0] SURR_LEAD  = 21'h0D800;
  localparam logic [CODE_W-1:0] SURR_TRAIL = 21'h0DC00;
  localparam logic [CODE_W-1:0] SURR_LOW   = 21'h003FF;

  // Result queue depth; the input side needs room for two results.
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CW    = $clog2(RQ_DEPTH + 1);

  // One result item.
  typedef struct packed {
    logic              char_valid;
    logic [CODE_W-1:0] code_value;
    logic              string_end;
    logic              last_of_item;
  } lpu8_res_t;

  // Results caused by one input item: count (0 to 2) and up to two results.
  typedef struct packed {
    logic [1:0] num;
    lpu8_res_t  res0;
    lpu8_res_t  res1;
  } lpu8_push_t;

endpackage

/* rtl/lpu8_decode.sv */
// Header parser and UTF-8 decode state, producing the results of each byte.
module lpu8_decode
  import lpu8_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              emit_utf16,
  output lpu8_push_t        push
);

  logic [1:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] len_low_r, len_low_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [1:0]        cont_r, cont_nxt;
  logic [CODE_W-1:0] acc_r, acc_nxt;

  // Next state and results for the byte on the input.
  always_comb begin
    logic [LEN_W-1:0]  len;
    logic              have;
    logic              ends;
    logic [CODE_W-1:0] value;
    logic [CODE_W-1:0] off;
    lpu8_res_t         marker;

    phase_nxt   = phase_r;
    len_low_nxt = len_low_r;
    left_nxt    = left_r;
    cont_nxt    = cont_r;
    acc_nxt     = acc_r;
    have        = 1'b0;
    ends        = 1'b0;
    value       = '0;
    len         = {data_byte, len_low_r};
    off         = '0;
    marker      = '{char_valid: 1'b0, code_value: '0, string_end: 1'b1, last_of_item: 1'b1};
    push        = '{num: 2'd0, res0: marker, res1: marker};

    if (phase_r == PH_LEN_HI) begin
      // Length high byte: load the count, an empty string closes at once.
      left_nxt = len;
      cont_nxt = 2'd0;
      acc_nxt  = '0;
      if (len == '0) begin
        phase_nxt = PH_LEN_LO;
        push.num  = 2'd1;
      end else begin
        phase_nxt = PH_BODY;
      end
    end else if (phase_r != PH_BODY) begin
      // Length low byte.
      len_low_nxt = data_byte;
      phase_nxt   = PH_LEN_HI;
    end else begin
      // Body byte.
      left_nxt = (left_r != '0) ? left_r - LEN_W'(1) : left_r;
      if (cont_r != 2'd0) begin
        acc_nxt  = {acc_r[CODE_W-7:0], data_byte[5:0] & CONT_MASK[5:0]};
        cont_nxt = cont_r - 2'd1;
        if (cont_r == 2'd1) begin
          have  = 1'b1;
          value = acc_nxt;
        end
      end else if (data_byte < LEAD2_MIN) begin
        have  = (data_byte != '0);
        value = CODE_W'(data_byte);
      end else if (data_byte < LEAD3_MIN) begin
        acc_nxt  = CODE_W'(data_byte & LEAD2_MASK);
        cont_nxt = 2'd1;
      end else if (data_byte < LEAD4_MIN) begin
        acc_nxt  = CODE_W'(data_byte & LEAD3_MASK);
        cont_nxt = 2'd2;
      end else begin
        acc_nxt  = CODE_W'(data_byte & LEAD4_MASK);
        cont_nxt = 2'd3;
      end

      ends = (left_nxt == '0) && (cont_nxt == 2'd0);
      if (ends) begin
        phase_nxt = PH_LEN_LO;
        acc_nxt   = '0;
      end

      // Emit the character, split into a surrogate pair where needed.
      if (have) begin
        if (emit_utf16 && (value >= SUPP_BASE)) begin
          off       = value - SUPP_BASE;
          push.num  = 2'd2;
          push.res0 = '{char_valid: 1'b1,
                        code_value: SURR_LEAD | CODE_W'(off[CODE_W-1:10]),
                        string_end: 1'b0, last_of_item: 1'b0};
          push.res1 = '{char_valid: 1'b1, code_value: SURR_TRAIL | (off & SURR_LOW),
                        string_end: ends, last_of_item: 1'b1};
        end else begin
          push.num  = 2'd1;
          push.res0 = '{char_valid: 1'b1, code_value: value,
                        string_end: ends, last_of_item: 1'b1};
        end
      end else if (ends) begin
        push.num = 2'd1;
      end
    end

    if (!fire) begin
      push.num = 2'd0;
    end
  end

  // State registers, updated on each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEN_LO;
      len_low_r <= '0;
      left_r    <= '0;
      cont_r    <= 2'd0;
      acc_r     <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      len_low_r <= len_low_nxt;
      left_r    <= left_nxt;
      cont_r    <= cont_nxt;
      acc_r     <= acc_nxt;
    end
  end

endmodule

/* rtl/lpu8_resq.sv */
// Small result queue that takes up to two results per cycle and sends one.
module lpu8_resq
  import lpu8_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  lpu8_push_t push,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output lpu8_res_t  out_res
);

  lpu8_res_t          slot_r [RQ_DEPTH];
  logic [RQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [RQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [RQ_CW-1:0]   count_r, count_nxt;
  logic               pop;

  assign out_valid = (count_r != '0);
  assign out_res   = slot_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room      = (count_r <= RQ_CW'(RQ_DEPTH - 2));

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RQ_AW'(push.num);
    rd_ptr_nxt = pop ? rd_ptr_r + RQ_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + RQ_CW'(push.num) - RQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Result slots.
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      slot_r[wr_ptr_r] <= push.res0;
    end
    if (push.num == 2'd2) begin
      slot_r[wr_ptr_r + RQ_AW'(1)] <= push.res1;
    end
  end

endmodule

/* rtl/length_prefixed_utf8_decoder.sv */
// Top level of the length-prefixed UTF-8 decoder.
//
// The input stream carries strings, each a 16-bit little-endian byte count
// followed by that many UTF-8 bytes, one byte per item on in_*. Every decoded
// character other than NUL leaves on out_* as one item (two for a surrogate
// pair when emit_utf16 is set). The last item of each string has out_tlast
// high; a string that ends without a character closes with a marker item whose
// char_valid bit is low. out_tuser[1] marks the last item caused by one byte.
// The cfg_* channel writes the emit_utf16 bit and is always ready; write it
// only while no item is in flight.
// An accepted byte is decoded in the same cycle and its results are written
// into a four-entry result queue, whose registered slots drive out_*. The
// block takes one byte per cycle as long as the queue has room for two
// results; a byte causes at most two results. When the receiver stalls,
// results wait in the queue and in_tready drops once more than two are
// waiting. Reset (rst_n low at a clock edge) empties the queue, clears
// emit_utf16 and returns the parser to the length low byte.
module length_prefixed_utf8_decoder
  import lpu8_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,     // emit_utf16
  // Byte input.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] data_byte
  // Result output.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [20:0] code_value, [23:21] zero
  output logic        out_tlast,    // string_end
  output logic [1:0]  out_tuser     // [0] char_valid, [1] last_of_item
);

  logic       emit_utf16_r;
  logic       fire;
  logic       room;
  lpu8_push_t push;
  lpu8_res_t  res;

  // Mode register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_utf16_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      emit_utf16_r <= cfg_data;
    end
  end

  // Input handshake.
  assign in_tready = room;
  assign fire      = in_tvalid && in_tready;

  lpu8_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .data_byte  (in_tdata),
    .emit_utf16 (emit_utf16_r),
    .push       (push)
  );

  lpu8_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Output packing.
  assign out_tdata = {3'b000, res.code_value};
  assign out_tlast = res.string_end;
  assign out_tuser = {res.last_of_item, res.char_valid};

endmodule
